/* src/pdad_pkg.sv */
// Shared types and constants of the pulse digitizer aggregate decoder.
`default_nettype none

package pdad_pkg;

  typedef enum logic [2:0] {
    PH_BOARD  = 3'd0,
    PH_CHAN0  = 3'd1,
    PH_CHAN1  = 3'd2,
    PH_TTAG   = 3'd3,
    PH_SAMPLE = 3'd4,
    PH_EXTRA1 = 3'd5,
    PH_EXTRA2 = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_EVENT   = 2'd1,
    KIND_BAD_TAG = 2'd2
  } kind_e;

  // Word positions inside the four-word board header.
  localparam logic [1:0] HDR_TAG   = 2'd0;
  localparam logic [1:0] HDR_MASK  = 2'd1;
  localparam logic [1:0] HDR_COUNT = 2'd2;
  localparam logic [1:0] HDR_LAST  = 2'd3;

  localparam logic [3:0] BOARD_TAG = 4'hA;

  // Channel header words plus the time tag and extra words of an event, and the event overhead.
  localparam logic [18:0] CHAN_HDR_PLUS_EVT = 19'd5;
  localparam logic [18:0] EVT_OVERHEAD      = 19'd3;

  typedef struct packed {
    kind_e        kind;
    logic [3:0]   channel;
    logic [13:0]  sample_a;
    logic [13:0]  sample_b;
    logic         dual_trace;
    logic [3:0]   probe_bits;
    logic [46:0]  timestamp;
    logic [14:0]  energy;
    logic [15:0]  baseline_quarters;
    logic         pileup;
    logic [4:0]   extras_code;
    logic [22:0]  event_counter;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [2:0] index;
  } pair_sel_t;

endpackage

`default_nettype wire

/* src/pdad_in_if.sv */
// Request channel carrying one readout word per transfer.
`default_nettype none

interface pdad_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        packet_start;

  modport source (output valid, word, packet_start, input ready);
  modport sink   (input valid, word, packet_start, output ready);
endinterface

`default_nettype wire

/* src/pdad_out_if.sv */
// Result channel carrying one decoded sample, event or bad-tag report.
`default_nettype none

interface pdad_out_if;
  import pdad_pkg::*;

  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [3:0]  channel;
  logic [13:0] sample_a;
  logic [13:0] sample_b;
  logic        dual_trace;
  logic [3:0]  probe_bits;
  logic [46:0] timestamp;
  logic [14:0] energy;
  logic [15:0] baseline_quarters;
  logic        pileup;
  logic [4:0]  extras_code;
  logic [22:0] event_counter;

  modport source (output valid, kind, channel, sample_a, sample_b, dual_trace, probe_bits,
                  timestamp, energy, baseline_quarters, pileup, extras_code, event_counter,
                  input ready);
  modport sink   (input valid, kind, channel, sample_a, sample_b, dual_trace, probe_bits,
                  timestamp, energy, baseline_quarters, pileup, extras_code, event_counter,
                  output ready);
endinterface

`default_nettype wire

/* src/pdad_pair_sel.sv */
// Finds the lowest enabled channel pair at or above a start index.
`default_nettype none

module pdad_pair_sel #(
  parameter int unsigned ChannelPairs = 8
) (
  input  logic [7:0]          mask_i,
  input  logic [3:0]          start_i,
  output pdad_pkg::pair_sel_t sel_o
);
  import pdad_pkg::*;

  // Scan from the top so the lowest qualifying pair wins.
  always_comb begin
    sel_o = '0;
    for (int p = 7; p >= 0; p--) begin
      if ((p < int'(ChannelPairs)) && (4'(p) >= start_i) && mask_i[p]) begin
        sel_o.found = 1'b1;
        sel_o.index = 3'(p);
      end
    end
  end

endmodule

`default_nettype wire

/* src/pdad_walker.sv */
// Packet walker: holds the parse state and decodes one word per cycle while accept_i is high.
`default_nettype none

module pdad_walker #(
  parameter int unsigned ChannelPairs = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [31:0]       word_i,
  input  logic              packet_start_i,
  output logic              res_valid_o,
  output pdad_pkg::result_t res_o
);
  import pdad_pkg::*;

  phase_e      phase_q, phase_d, phase_eff;
  logic [1:0]  hidx_q, hidx_d, hidx_eff;
  logic [7:0]  mask_q, mask_d;
  logic [2:0]  pidx_q, pidx_d;
  logic [22:0] counter_q, counter_d;
  logic [30:0] wleft_q, wleft_d;
  logic [17:0] spe_q, spe_d;
  logic [17:0] sleft_q, sleft_d;
  logic        trace_q, trace_d;
  logic [3:0]  chan_q, chan_d;
  logic [30:0] ttag_q, ttag_d;
  logic [31:0] extra_q, extra_d;

  logic [3:0]  sel_start;
  pair_sel_t   sel;
  logic [17:0] spe_new;
  logic [18:0] need_hdr;
  logic [18:0] need_evt;

  assign phase_eff = packet_start_i ? PH_BOARD : phase_q;
  assign hidx_eff  = packet_start_i ? HDR_TAG : hidx_q;
  assign sel_start = (phase_eff == PH_BOARD) ? 4'd0 : ({1'b0, pidx_q} + 4'd1);
  assign spe_new   = {word_i[15:0], 2'b00};
  // Size minus the two header words must hold one event: size >= words + 5.
  assign need_hdr  = {1'b0, spe_new} + CHAN_HDR_PLUS_EVT;
  assign need_evt  = {1'b0, spe_q} + EVT_OVERHEAD;

  pdad_pair_sel #(
    .ChannelPairs(ChannelPairs)
  ) u_pair_sel (
    .mask_i (mask_q),
    .start_i(sel_start),
    .sel_o  (sel)
  );

  // Next-state logic.
  always_comb begin
    phase_d   = phase_eff;
    hidx_d    = hidx_eff;
    mask_d    = mask_q;
    pidx_d    = pidx_q;
    counter_d = counter_q;
    wleft_d   = wleft_q;
    spe_d     = spe_q;
    sleft_d   = sleft_q;
    trace_d   = trace_q;
    chan_d    = chan_q;
    ttag_d    = ttag_q;
    extra_d   = extra_q;
    unique case (phase_eff)
      PH_BOARD: begin
        unique case (hidx_eff)
          HDR_TAG:   hidx_d = HDR_MASK;
          HDR_MASK: begin
            mask_d = word_i[7:0];
            hidx_d = HDR_COUNT;
          end
          HDR_COUNT: begin
            counter_d = word_i[22:0];
            hidx_d    = HDR_LAST;
          end
          default: begin
            hidx_d = HDR_TAG;
            if (sel.found) begin
              pidx_d  = sel.index;
              phase_d = PH_CHAN0;
            end else begin
              phase_d = PH_BOARD;
            end
          end
        endcase
      end
      PH_CHAN0: begin
        wleft_d = word_i[30:0];
        phase_d = PH_CHAN1;
      end
      PH_CHAN1: begin
        trace_d = word_i[31];
        spe_d   = spe_new;
        if (wleft_q >= {12'd0, need_hdr}) begin
          wleft_d = wleft_q - {12'd0, need_hdr};
          phase_d = PH_TTAG;
        end else begin
          // The pair holds no whole event, so the size count no longer matters.
          wleft_d = (wleft_q >= 31'd2) ? wleft_q - 31'd2 : 31'd0;
          if (sel.found) begin
            pidx_d  = sel.index;
            phase_d = PH_CHAN0;
          end else begin
            phase_d = PH_BOARD;
            hidx_d  = HDR_TAG;
          end
        end
      end
      PH_TTAG: begin
        chan_d  = {pidx_q, word_i[31]};
        ttag_d  = word_i[30:0];
        sleft_d = spe_q;
        phase_d = (spe_q != '0) ? PH_SAMPLE : PH_EXTRA1;
      end
      PH_SAMPLE: begin
        sleft_d = (sleft_q != '0) ? sleft_q - 18'd1 : '0;
        if (sleft_q <= 18'd1) begin
          phase_d = PH_EXTRA1;
        end
      end
      PH_EXTRA1: begin
        extra_d = word_i;
        phase_d = PH_EXTRA2;
      end
      default: begin
        if (wleft_q >= {12'd0, need_evt}) begin
          wleft_d = wleft_q - {12'd0, need_evt};
          phase_d = PH_TTAG;
        end else if (sel.found) begin
          pidx_d  = sel.index;
          phase_d = PH_CHAN0;
        end else begin
          phase_d = PH_BOARD;
          hidx_d  = HDR_TAG;
        end
      end
    endcase
  end

  // Result decode.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_eff) inside
      PH_BOARD: begin
        if ((hidx_eff == HDR_TAG) && (word_i[31:28] != BOARD_TAG)) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_TAG;
        end
      end
      PH_CHAN0, PH_CHAN1, PH_TTAG, PH_EXTRA1: begin
        res_valid_o = 1'b0;
      end
      PH_SAMPLE: begin
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_SAMPLE;
        res_o.channel       = chan_q;
        res_o.sample_a      = word_i[13:0];
        res_o.sample_b      = word_i[29:16];
        res_o.dual_trace    = trace_q;
        res_o.probe_bits    = {word_i[31], word_i[15], word_i[30], word_i[14]};
        res_o.event_counter = counter_q;
      end
      default: begin
        res_valid_o             = 1'b1;
        res_o.kind              = KIND_EVENT;
        res_o.channel           = chan_q;
        res_o.dual_trace        = trace_q;
        res_o.timestamp         = {extra_q[31:16], ttag_q};
        res_o.energy            = word_i[14:0];
        res_o.baseline_quarters = extra_q[15:0];
        res_o.pileup            = word_i[15];
        res_o.extras_code       = word_i[20:16];
        res_o.event_counter     = counter_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BOARD;
      hidx_q    <= HDR_TAG;
      mask_q    <= '0;
      pidx_q    <= '0;
      counter_q <= '0;
      wleft_q   <= '0;
      spe_q     <= '0;
      sleft_q   <= '0;
      trace_q   <= 1'b0;
      chan_q    <= '0;
      ttag_q    <= '0;
      extra_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      mask_q    <= mask_d;
      pidx_q    <= pidx_d;
      counter_q <= counter_d;
      wleft_q   <= wleft_d;
      spe_q     <= spe_d;
      sleft_q   <= sleft_d;
      trace_q   <= trace_d;
      chan_q    <= chan_d;
      ttag_q    <= ttag_d;
      extra_q   <= extra_d;
    end
  end

endmodule

`default_nettype wire

/* src/pulse_digitizer_aggregate_decoder_core.sv */
// Top level of the pulse digitizer aggregate decoder with its two-entry result stage.
//
// Walks a digitizer readout packet one 32-bit word per request: board header, channel
// pair headers, then time tag, sample words and two extra words for every event. It
// takes one word per clock cycle while the input is not held off; each word is decoded
// in the same cycle it is accepted and any result is registered at that edge, so it is
// offered on the next cycle when the result side keeps up. A two-entry result stage (head
// register plus skid register) lets the input keep flowing after the result side stalls
// until one more result is waiting; words that give no result still pass, and the input
// is held off only while both entries are full. Asserting packet_start with a word
// restarts the walk at the board header.
`default_nettype none

module pulse_digitizer_aggregate_decoder_core #(
  parameter int unsigned CHANNEL_PAIRS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pdad_in_if.sink           in_i,
  pdad_out_if.source        out_o
);
  import pdad_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    push, pop;

  logic    head_valid_q, head_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  pdad_walker #(
    .ChannelPairs(CHANNEL_PAIRS)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .word_i        (in_i.word),
    .packet_start_i(in_i.packet_start),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign push = accept && res_valid;
  assign pop  = head_valid_q && out_o.ready;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        head_d = res;
      end else begin
        head_valid_d = 1'b0;
      end
    end else if (push) begin
      if (head_valid_q) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        head_d       = res;
        head_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_o.valid             = head_valid_q;
  assign out_o.kind              = head_q.kind;
  assign out_o.channel           = head_q.channel;
  assign out_o.sample_a          = head_q.sample_a;
  assign out_o.sample_b          = head_q.sample_b;
  assign out_o.dual_trace        = head_q.dual_trace;
  assign out_o.probe_bits        = head_q.probe_bits;
  assign out_o.timestamp         = head_q.timestamp;
  assign out_o.energy            = head_q.energy;
  assign out_o.baseline_quarters = head_q.baseline_quarters;
  assign out_o.pileup            = head_q.pileup;
  assign out_o.extras_code       = head_q.extras_code;
  assign out_o.event_counter     = head_q.event_counter;

endmodule

`default_nettype wire
